// File: hdl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, types and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // input component width, Q1.14
    localparam int QW = 16;
    // quadratic terms scaled by 2^28, signed
    localparam int SUM_W = 35;
    // cordic datapath width
    localparam int CW = 44;
    // binary angle width, one turn = 2^32
    localparam int ZW = 32;
    // normalization target: magnitude ends in [2^40, 2^41)
    localparam int NORM_TOP   = 41;
    localparam int NORM_STEPS = 6;
    // square root: 57-bit radicand, one result bit per cell
    localparam int SQ_W       = 58;
    localparam int SQRT_STEPS = 29;

    localparam logic [ZW-1:0] Z_HALF_TURN = 32'h8000_0000;
    localparam logic [ZW-1:0] Z_PLUS_90   = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_MINUS_90  = 32'hC000_0000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
        logic                 zero;
    } t_cord;

    // atan(2^-i) in binary angle units
    function automatic logic [ZW-1:0] f_atan(input int idx);
        logic [ZW-1:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/q2e_in_if.sv
// ----------------------------------------------------------------------------
// q2e_in_if
// Quaternion input channel: valid/ready handshake with four Q1.14 components.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [q2e_pkg::QW-1:0]   quat_w;
    logic signed [q2e_pkg::QW-1:0]   quat_x;
    logic signed [q2e_pkg::QW-1:0]   quat_y;
    logic signed [q2e_pkg::QW-1:0]   quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

`default_nettype wire

// File: hdl/q2e_out_if.sv
// ----------------------------------------------------------------------------
// q2e_out_if
// Euler angle output channel: valid/ready handshake with three binary angles
// and the gimbal lock flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_out_if #(
    parameter int ANGLE_BITS = q2e_pkg::ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic                         pitch_clamped;

    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One step of a restoring integer square root, one result bit per cell, with
// a side word carried along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
    parameter int K      = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [q2e_pkg::SQ_W-1:0]    i_v,
    input  wire logic [q2e_pkg::SQ_W-1:0]    i_res,
    input  wire logic [SIDE_W-1:0]           i_side,
    output logic      [q2e_pkg::SQ_W-1:0]    o_v,
    output logic      [q2e_pkg::SQ_W-1:0]    o_res,
    output logic      [SIDE_W-1:0]           o_side
);

    localparam logic [q2e_pkg::SQ_W-1:0] BIT = q2e_pkg::SQ_W'(1) << (2 * K);

    logic [q2e_pkg::SQ_W-1:0] trial;
    logic [q2e_pkg::SQ_W-1:0] n_v;
    logic [q2e_pkg::SQ_W-1:0] n_res;

    always_comb begin
        trial = i_res + BIT;
        if (i_v >= trial) begin
            n_v   = i_v - trial;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_v   = i_v;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v    <= n_v;
            o_res  <= n_res;
            o_side <= i_side;
        end
    end

endmodule

`default_nettype wire

// File: hdl/q2e_norm_cell.sv
// ----------------------------------------------------------------------------
// q2e_norm_cell
// One step of the normalizing shift: shifts the vector left by SHIFT when
// that keeps its larger magnitude below 2^41.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_norm_cell #(
    parameter int SHIFT = 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire q2e_pkg::t_cord i_d,
    output q2e_pkg::t_cord      o_q
);

    logic [q2e_pkg::CW-1:0] ay;
    logic [q2e_pkg::CW-1:0] mag;
    q2e_pkg::t_cord         n_q;

    always_comb begin
        // x is never negative here
        ay  = i_d.y[q2e_pkg::CW-1] ? q2e_pkg::CW'(-i_d.y) : i_d.y;
        mag = i_d.x | ay;
        n_q = i_d;
        if ((mag >> (q2e_pkg::NORM_TOP - SHIFT)) == '0) begin
            n_q.x = i_d.x <<< SHIFT;
            n_q.y = i_d.y <<< SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end

endmodule

`default_nettype wire

// File: hdl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation driving y toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire q2e_pkg::t_cord i_d,
    output q2e_pkg::t_cord      o_q
);

    localparam logic [q2e_pkg::ZW-1:0] ANG = q2e_pkg::f_atan(IDX);

    logic signed [q2e_pkg::CW-1:0] xs;
    logic signed [q2e_pkg::CW-1:0] ys;
    q2e_pkg::t_cord                n_q;

    always_comb begin
        xs  = i_d.x >>> IDX;
        ys  = i_d.y >>> IDX;
        n_q = i_d;
        if (i_d.y > 0) begin
            n_q.x = i_d.x + ys;
            n_q.y = i_d.y - xs;
            n_q.z = i_d.z + ANG;
        end else begin
            n_q.x = i_d.x - ys;
            n_q.y = i_d.y + xs;
            n_q.z = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_q <= n_q;
        end
    end

endmodule

`default_nettype wire

// File: hdl/q2e_atan2.sv
// ----------------------------------------------------------------------------
// q2e_atan2
// Pipelined atan2: half-plane fold, normalizing shift chain, then a row of
// CORDIC cells.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_atan2 #(
    parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [q2e_pkg::SUM_W-1:0]  i_y,
    input  wire logic signed [q2e_pkg::SUM_W-1:0]  i_x,
    output logic             [q2e_pkg::ZW-1:0]     o_z
);

    q2e_pkg::t_cord n_pre;
    q2e_pkg::t_cord r_pre;
    q2e_pkg::t_cord norm_q [q2e_pkg::NORM_STEPS+1];
    q2e_pkg::t_cord cord_q [STAGES+1];

    always_comb begin
        n_pre.zero = (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            n_pre.x = q2e_pkg::CW'(-i_x);
            n_pre.y = q2e_pkg::CW'(-i_y);
            n_pre.z = q2e_pkg::Z_HALF_TURN;
        end else begin
            n_pre.x = q2e_pkg::CW'(i_x);
            n_pre.y = q2e_pkg::CW'(i_y);
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    assign norm_q[0] = r_pre;

    for (genvar j = 0; j < q2e_pkg::NORM_STEPS; j++) begin : g_norm
        q2e_norm_cell #(
            .SHIFT(1 << (q2e_pkg::NORM_STEPS - 1 - j))
        ) u_cell (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_d  (norm_q[j]),
            .o_q  (norm_q[j+1])
        );
    end

    assign cord_q[0] = norm_q[q2e_pkg::NORM_STEPS];

    for (genvar i = 0; i < STAGES; i++) begin : g_cordic
        q2e_cordic_cell #(
            .IDX(i)
        ) u_cell (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_d  (cord_q[i]),
            .o_q  (cord_q[i+1])
        );
    end

    // atan2(0, 0) is defined as zero
    assign o_z = cord_q[STAGES].zero ? '0 : cord_q[STAGES].z;

endmodule

`default_nettype wire

// File: hdl/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler
// Unit quaternion to roll, pitch and yaw (aerospace ZYX) in binary angles.
// ----------------------------------------------------------------------------
// Fully pipelined: one quaternion transaction is taken every clock while the
// pipeline is not stalled. The depth is set by the 29-cell square root chain
// that builds the cosine leg for pitch and the row of CORDIC cells behind it;
// the three atan2 units run side by side. A single pipeline-wide enable
// stalls every stage while a finished result waits in the output register,
// so ready is low only while that register is full and not being taken. Roll
// and yaw are atan2 of the quadratic terms; pitch is atan2(s, sqrt(1 - s^2))
// with s = 2(wy - zx). When |s| reaches one, pitch is forced to +-pi/2 with
// the sign of s and pitch_clamped is set. Angles are rounded half up to
// ANGLE_BITS bits, where 2^(ANGLE_BITS-1) is pi; an angle of pi wraps to -pi.
// Inputs outside the unit sphere are accepted and evaluated exactly.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler #(
    parameter int ANGLE_BITS    = q2e_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    q2e_in_if.sink     i_quat,
    q2e_out_if.source  o_euler
);

    localparam int SW       = q2e_pkg::SUM_W;
    localparam int ATAN_LAT = 1 + q2e_pkg::NORM_STEPS + CORDIC_STAGES;
    localparam int PIPE     = 3 + q2e_pkg::SQRT_STEPS + ATAN_LAT + 1;
    // side word through the square root: sr, cr, sp, sy, cy, clamp, sign
    localparam int SIDE_W   = 5 * SW + 2;
    localparam int SH       = q2e_pkg::ZW - ANGLE_BITS;
    localparam logic [q2e_pkg::ZW-1:0] HALF =
        (SH == 0) ? '0 : (q2e_pkg::ZW'(1) << (SH - 1));
    localparam logic signed [SW-1:0]   ONE_Q28 = SW'(1) << 28;
    localparam logic [q2e_pkg::SQ_W-1:0] RAD_TOP = q2e_pkg::SQ_W'(1) << 56;
    localparam logic signed [ANGLE_BITS-1:0] PITCH_MAX =
        ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    // rounds a 32-bit binary angle to the output width
    function automatic logic [ANGLE_BITS-1:0] f_round(input logic [q2e_pkg::ZW-1:0] z);
        logic [q2e_pkg::ZW-1:0] sum;
        sum = z + HALF;
        return sum[q2e_pkg::ZW-1:SH];
    endfunction

    // pipeline control: every stage advances together
    logic            en;
    logic [PIPE-1:0] r_vld;

    assign en           = !r_vld[PIPE-1] || o_euler.ready;
    assign i_quat.ready = en;
    assign o_euler.valid = r_vld[PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE-2:0], i_quat.valid};
        end
    end

    // stage 1: component products
    logic signed [2*q2e_pkg::QW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_zx <= i_quat.quat_z * i_quat.quat_x;
            r_wz <= i_quat.quat_w * i_quat.quat_z;
            r_xy <= i_quat.quat_x * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
        end
    end

    // stage 2: quadratic terms scaled by 2^28
    logic signed [SW-1:0] n_sr, n_cr, n_sp, n_sy, n_cy, n_asp;
    logic signed [SW-1:0] r_sr, r_cr, r_sp, r_sy, r_cy, r_asp;
    logic                 r_clamp, r_spos;

    always_comb begin
        n_sr  = (SW'(r_wx) + SW'(r_yz)) <<< 1;
        n_cr  = ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        n_sp  = (SW'(r_wy) - SW'(r_zx)) <<< 1;
        n_sy  = (SW'(r_wz) + SW'(r_xy)) <<< 1;
        n_cy  = ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        n_asp = (n_sp < 0) ? -n_sp : n_sp;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sr    <= n_sr;
            r_cr    <= n_cr;
            r_sp    <= n_sp;
            r_sy    <= n_sy;
            r_cy    <= n_cy;
            r_asp   <= n_asp;
            // gimbal lock when |s| reaches one
            r_clamp <= n_asp >= ONE_Q28;
            r_spos  <= n_sp > 0;
        end
    end

    // stage 3: radicand 2^56 - s^2 (only meaningful when not clamped)
    logic [55:0]               sq;
    logic [q2e_pkg::SQ_W-1:0]  r_rad;
    logic [SIDE_W-1:0]         r_side;

    assign sq = r_asp[27:0] * r_asp[27:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad  <= RAD_TOP - q2e_pkg::SQ_W'(sq);
            r_side <= {r_sr, r_cr, r_sp, r_sy, r_cy, r_clamp, r_spos};
        end
    end

    // square root chain, one result bit per cell
    logic [q2e_pkg::SQ_W-1:0] sq_v    [q2e_pkg::SQRT_STEPS+1];
    logic [q2e_pkg::SQ_W-1:0] sq_res  [q2e_pkg::SQRT_STEPS+1];
    logic [SIDE_W-1:0]        sq_side [q2e_pkg::SQRT_STEPS+1];

    assign sq_v[0]    = r_rad;
    assign sq_res[0]  = '0;
    assign sq_side[0] = r_side;

    for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_sqrt
        q2e_sqrt_cell #(
            .K     (q2e_pkg::SQRT_STEPS - 1 - k),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_v   (sq_v[k]),
            .i_res (sq_res[k]),
            .i_side(sq_side[k]),
            .o_v   (sq_v[k+1]),
            .o_res (sq_res[k+1]),
            .o_side(sq_side[k+1])
        );
    end

    // unpack after the square root
    logic signed [SW-1:0] a_sr, a_cr, a_sp, a_sy, a_cy, a_cp;
    logic                 a_clamp, a_spos;

    assign {a_sr, a_cr, a_sp, a_sy, a_cy, a_clamp, a_spos} = sq_side[q2e_pkg::SQRT_STEPS];
    assign a_cp = sq_res[q2e_pkg::SQRT_STEPS][SW-1:0];

    // three atan2 units side by side
    logic [q2e_pkg::ZW-1:0] z_roll, z_pitch, z_yaw;

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(en), .i_y(a_sr), .i_x(a_cr), .o_z(z_roll)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(en), .i_y(a_sp), .i_x(a_cp), .o_z(z_pitch)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(en), .i_y(a_sy), .i_x(a_cy), .o_z(z_yaw)
    );

    // clamp flag and sign ride alongside the atan2 units
    logic [1:0] r_fdly [ATAN_LAT];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fdly[0] <= {a_clamp, a_spos};
            for (int j = 1; j < ATAN_LAT; j++) begin
                r_fdly[j] <= r_fdly[j-1];
            end
        end
    end

    // output register
    logic                   f_clamp, f_spos;
    logic [q2e_pkg::ZW-1:0] z_pitch_sel;
    logic [ANGLE_BITS-1:0]  r_roll, r_pitch, r_yaw;
    logic                   r_clamp_out;

    assign {f_clamp, f_spos} = r_fdly[ATAN_LAT-1];

    always_comb begin
        if (f_clamp) begin
            z_pitch_sel = f_spos ? q2e_pkg::Z_PLUS_90 : q2e_pkg::Z_MINUS_90;
        end else begin
            z_pitch_sel = z_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_roll      <= f_round(z_roll);
            r_pitch     <= f_round(z_pitch_sel);
            r_yaw       <= f_round(z_yaw);
            r_clamp_out <= f_clamp;
        end
    end

    assign o_euler.roll_angle    = r_roll;
    assign o_euler.pitch_angle   = r_pitch;
    assign o_euler.yaw_angle     = r_yaw;
    assign o_euler.pitch_clamped = r_clamp_out;

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_euler.valid)
        else $error("output valid right after reset");

    // a clamped pitch is exactly +pi/2 or -pi/2
    a_clamp_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && o_euler.pitch_clamped |->
            (o_euler.pitch_angle == PITCH_MAX) || (o_euler.pitch_angle == -PITCH_MAX))
        else $error("clamped pitch is not a right angle");

    // a stalled result stays put in the output register
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid && !o_euler.ready |=> o_euler.valid && $stable(r_roll)
            && $stable(r_pitch) && $stable(r_yaw))
        else $error("output register changed under stall");

endmodule

`default_nettype wire

// File: bench/tb_quaternion_to_euler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler
// Self-checking bench for the quaternion to Euler angle converter. Directed
// rows (identity, gimbal lock, half turns, zero vector, component extremes)
// then about 600 random quaternions, mostly near unit length. Every angle
// transaction is compared field by field against a bit-true predictor.
// ----------------------------------------------------------------------------

module tb_quaternion_to_euler;

    localparam int N_RANDOM = 600;
    // pipeline depth at the default of 16 cordic stages
    localparam int PIPE_LAT = 56;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } t_euler;

    // one directed row: known says the expected angles are typed in
    typedef struct packed {
        t_quat  q;
        logic   known;
        t_euler e;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    q2e_in_if  quat_if ();
    q2e_out_if euler_if ();

    quaternion_to_euler u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_if.sink),
        .o_euler (euler_if.source)
    );

    t_euler angle_queue[$];
    int     n_errors   = 0;
    int     n_sent     = 0;
    int     n_checked  = 0;
    int     n_locked   = 0;
    bit     rx_stalls  = 1'b1;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // floor division by 2^k
    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bit_w;
        res   = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring cordic, 32-bit binary angle
    function automatic logic [31:0] vector_angle(longint sy, longint cx);
        logic [31:0] acc;
        longint      ax, ay, nx;
        acc = '0;
        if (cx == 0 && sy == 0) return '0;
        if (cx < 0) begin
            cx  = -cx;
            sy  = -sy;
            acc = q2e_pkg::Z_HALF_TURN;
        end
        ax = cx;
        ay = (sy < 0) ? -sy : sy;
        // bring magnitude into [2^40, 2^41)
        while (ax < (64'sd1 <<< 40) && ay < (64'sd1 <<< 40)) begin
            cx = cx * 2; sy = sy * 2; ax = ax * 2; ay = ay * 2;
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES_DEF; i++) begin
            if (sy > 0) begin
                nx  = cx + floor_shr(sy, i);
                sy  = sy - floor_shr(cx, i);
                acc = acc + q2e_pkg::f_atan(i);
            end else begin
                nx  = cx - floor_shr(sy, i);
                sy  = sy + floor_shr(cx, i);
                acc = acc - q2e_pkg::f_atan(i);
            end
            cx = nx;
        end
        return acc;
    endfunction

    // round half up to a 16-bit binary angle
    function automatic logic [15:0] round_angle(logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h0000_8000;
        return r[31:16];
    endfunction

    function automatic t_euler zyx_angles(t_quat q);
        longint      w, x, y, z, sr, cr, sp, sy, cy, asp;
        logic [31:0] pz;
        t_euler      e;
        w  = q.w; x = q.x; y = q.y; z = q.z;
        sr = 2 * (w * x + y * z);
        cr = (64'sd1 <<< 28) - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        sy = 2 * (w * z + x * y);
        cy = (64'sd1 <<< 28) - 2 * (y * y + z * z);
        asp = (sp < 0) ? -sp : sp;
        e.clamped = 1'b0;
        if (asp >= (64'sd1 <<< 28)) begin
            // gimbal lock: pitch forced to +-pi/2
            pz        = (sp > 0) ? q2e_pkg::Z_PLUS_90 : q2e_pkg::Z_MINUS_90;
            e.clamped = 1'b1;
        end else begin
            pz = vector_angle(sp, int_sqrt((64'd1 << 56) - longint'(asp * asp)));
        end
        e.roll  = round_angle(vector_angle(sr, cr));
        e.pitch = round_angle(pz);
        e.yaw   = round_angle(vector_angle(sy, cy));
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset and limit
    // ------------------------------------------------------------------------

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: stall pattern and checking
    // ------------------------------------------------------------------------

    logic [7:0] stall_lfsr = 8'hA5;
    initial euler_if.ready = 1'b0;

    always @(posedge i_clk) begin
        stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^
                       stall_lfsr[4] ^ stall_lfsr[3]};
        // stall about a quarter of the time while stalls are enabled
        euler_if.ready <= i_rst_n && !(rx_stalls && stall_lfsr[1:0] == 2'b00);
    end

    always @(posedge i_clk) begin
        t_euler got, want;
        if (i_rst_n && euler_if.valid && euler_if.ready) begin
            got = {euler_if.roll_angle, euler_if.pitch_angle,
                   euler_if.yaw_angle, euler_if.pitch_clamped};
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected angle transaction %h", $time, got);
                n_errors++;
            end else begin
                want = angle_queue.pop_front();
                n_checked++;
                if (got.roll !== want.roll) begin
                    $display("%0t: roll expected %0d actual %0d",
                             $time, want.roll, got.roll);
                    n_errors++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d",
                             $time, want.pitch, got.pitch);
                    n_errors++;
                end
                if (got.yaw !== want.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d",
                             $time, want.yaw, got.yaw);
                    n_errors++;
                end
                if (got.clamped !== want.clamped) begin
                    $display("%0t: pitch_clamped expected %0b actual %0b",
                             $time, want.clamped, got.clamped);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------

    // hold one quaternion until accepted; valid stays up between back-to-back
    task automatic send_quat(t_quat q, logic known, t_euler typed);
        t_euler e;
        quat_if.valid  <= 1'b1;
        quat_if.quat_w <= q.w;
        quat_if.quat_x <= q.x;
        quat_if.quat_y <= q.y;
        quat_if.quat_z <= q.z;
        e = zyx_angles(q);
        if (known && e !== typed) begin
            $display("%0t: predictor disagrees with typed row, expected %h actual %h",
                     $time, typed, e);
            n_errors++;
        end
        if (e.clamped) n_locked++;
        angle_queue.push_back(known ? typed : e);
        do @(posedge i_clk); while (!quat_if.ready);
        n_sent++;
    endtask

    task automatic idle_cycles(int n);
        quat_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0:       return 16'(int'($urandom_range(32767)) - 16384);
            1:       return 16'($urandom);
            default: return 16'(int'($urandom_range(16384)) - 8192);
        endcase
    endfunction

    // random rotation, mostly near unit length: scale a random vector to norm 16384
    function automatic t_quat rand_quat();
        t_quat q;
        real   a, b, c, d, n;
        if ($urandom_range(9) == 0) begin
            // raw components, out-of-range and non-unit included
            q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
            return q;
        end
        a = real'(int'($urandom_range(2000)) - 1000);
        b = real'(int'($urandom_range(2000)) - 1000);
        c = real'(int'($urandom_range(2000)) - 1000);
        d = real'(int'($urandom_range(2000)) - 1000);
        if ($urandom_range(5) == 0) begin
            // steer toward gimbal lock: w = y, z = -x
            c = a; d = -b;
        end
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        q.w = 16'($rtoi(a * 16384.0 / n));
        q.x = 16'($rtoi(b * 16384.0 / n));
        q.y = 16'($rtoi(c * 16384.0 / n));
        q.z = 16'($rtoi(d * 16384.0 / n));
        return q;
    endfunction

    // directed rows; expected angles typed in where obvious
    localparam int N_ROWS = 14;
    localparam t_row DIRECTED [N_ROWS] = '{
        // identity
        '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
        // all zero: sine terms vanish, cosine terms one
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b0}},
        // half turn about x: roll wraps to -pi
        '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, '0},
        // half turn about z: yaw wraps to -pi
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
        // just short of gimbal lock, pitch near +pi/2
        '{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 1'b0, '0},
        // just short of gimbal lock, pitch near -pi/2
        '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}, 1'b0, '0},
        // exact |s| = 1, pitch clamped to +pi/2
        '{'{16'sd8192, 16'sd8192, 16'sd8192, -16'sd8192}, 1'b0, '0},
        // half turn about y, s = 0
        '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, '0},
        // component extremes
        '{'{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384}, 1'b0, '0},
        '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, '0},
        '{'{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000}, 1'b0, '0},
        '{'{16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000}, 1'b0, '0},
        // small rotation
        '{'{16'sd16383, 16'sd100, -16'sd50, 16'sd25}, 1'b0, '0}
    };

    initial begin
        int     burst;
        t_euler none;
        none            = '0;
        i_rst_n         = 1'b0;
        quat_if.valid   = 1'b0;
        quat_if.quat_w  = '0;
        quat_if.quat_x  = '0;
        quat_if.quat_y  = '0;
        quat_if.quat_z  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) send_quat(DIRECTED[r].q, DIRECTED[r].known, DIRECTED[r].e);
        idle_cycles(1);

        // pause until every expected angle set has come
        while (angle_queue.size() != 0) @(posedge i_clk);

        // random bursts with random gaps; a stretch without stalls in the middle
        while (n_sent < N_ROWS + N_RANDOM) begin
            rx_stalls = !(n_sent > 250 && n_sent < 350);
            burst = $urandom_range(40, 1);
            repeat (burst) send_quat(rand_quat(), 1'b0, none);
            if (rx_stalls || $urandom_range(3) == 0) idle_cycles($urandom_range(6, 1));
        end
        idle_cycles(1);
        rx_stalls = 1'b1;

        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);

        $display("sent %0d quaternions, %0d angle sets checked, %0d in gimbal lock",
                 n_sent, n_checked, n_locked);
        if (n_errors == 0 && angle_queue.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
